// ----- rtl/core/tlq_pkg.sv -----
// Shared types and constants for the tree label distance query block.
`default_nettype none
package tlq_pkg;

    localparam int NODE_LIMIT    = 1024;
    localparam int MAX_LEVELS    = 11;
    localparam int MAX_LABELS    = 65536;
    localparam int MAX_POSITIONS = 16384;
    localparam int DIST_BITS     = 32;
    localparam int LIFT_DEPTH    = MAX_LEVELS * NODE_LIMIT;
    localparam int ROW_DEPTH     = NODE_LIMIT + 1;
    localparam int NODE_W        = 10;
    localparam int LSTART_W      = 17;
    localparam int PSTART_W      = 15;
    localparam int LIFT_AW       = 14;
    localparam int ROW_AW        = 11;
    localparam int LABEL_AW      = 16;
    localparam int POS_AW        = 14;
    localparam int QUEUE_DEPTH   = 2;

    typedef enum logic [3:0] {
        CMD_QUERY  = 4'd0,
        CMD_DEPTH  = 4'd1,
        CMD_PARENT = 4'd2,
        CMD_LIFT   = 4'd3,
        CMD_LSTART = 4'd4,
        CMD_OUTLBL = 4'd5,
        CMD_INLBL  = 4'd6,
        CMD_PSTART = 4'd7,
        CMD_POS    = 4'd8
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_INF   = 2'd2
    } t_status;

    typedef enum logic {
        REG_NODES  = 1'b0,
        REG_LEVELS = 1'b1
    } t_reg_idx;

    typedef struct packed {
        t_cmd                cmd;
        logic [15:0]         addr;
        logic [31:0]         value;
        logic [NODE_W-1:0]   src;
        logic [NODE_W-1:0]   dst;
    } t_req;

endpackage
`default_nettype wire

// ----- rtl/core/tlq_front.sv -----
// Front end: request intake, command classification and a short request queue.
`default_nettype none
module tlq_front import tlq_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [3:0]  i_command,
    input  wire logic [15:0] i_table_address,
    input  wire logic [31:0] i_write_value,
    input  wire logic [9:0]  i_source_node,
    input  wire logic [9:0]  i_target_node,
    output logic             o_q_valid,
    output t_req             o_q_req,
    input  wire logic        i_q_pop
);

    t_req        r_q [QUEUE_DEPTH];
    logic        r_wr, r_rd;
    logic [1:0]  r_count;
    logic        accept, push;

    assign o_in_stall = (r_count == 2'(QUEUE_DEPTH));
    assign accept     = i_in_valid && !o_in_stall;
    // unknown commands are dropped here and never reach the back end
    assign push       = accept && (i_command <= CMD_POS);
    assign o_q_valid  = (r_count != 2'd0);
    assign o_q_req    = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= '{cmd: t_cmd'(i_command), addr: i_table_address,
                           value: i_write_value, src: i_source_node,
                           dst: i_target_node};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) r_wr <= ~r_wr;
            if (i_q_pop) r_rd <= ~r_rd;
            r_count <= r_count + 2'(push) - 2'(i_q_pop);
        end
    end

`ifndef SYNTH
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'(QUEUE_DEPTH)) else $error("queue overfilled");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_pop |-> r_count != 2'd0) else $error("pop from empty queue");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> r_count < 2'(QUEUE_DEPTH)) else $error("push into full queue");
`endif

endmodule
`default_nettype wire

// ----- rtl/core/tlq_back.sv -----
// Back end: index tables, config registers, query sequencer and result register.
`default_nettype none
module tlq_back import tlq_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [10:0] i_cfg_data,
    input  wire logic        i_q_valid,
    input  wire t_req        i_q_req,
    output logic             o_q_pop,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_distance,
    output logic [1:0]       o_status
);

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_DEPTH = 13'b0000000000010,
        S_UP    = 13'b0000000000100,
        S_UPW   = 13'b0000000001000,
        S_DN    = 13'b0000000010000,
        S_DNW   = 13'b0000000100000,
        S_PAR   = 13'b0000001000000,
        S_PS    = 13'b0000010000000,
        S_PSW   = 13'b0000100000000,
        S_WALK  = 13'b0001000000000,
        S_WP    = 13'b0010000000000,
        S_WL    = 13'b0100000000000,
        S_DONE  = 13'b1000000000000
    } t_state;

    localparam logic [31:0] ALL_ONES = '1;

    function automatic logic [LIFT_AW-1:0] lift_idx(input logic [3:0] lv,
                                                    input logic [10:0] n,
                                                    input logic [9:0] node);
        logic [14:0] s;
        s = 15'(lv) * 15'(n) + 15'(node);
        return s[LIFT_AW-1:0];
    endfunction

    // tables
    logic [NODE_W-1:0]   r_depth_mem  [NODE_LIMIT];
    logic [NODE_W-1:0]   r_parent_mem [NODE_LIMIT];
    logic [NODE_W-1:0]   r_lift_mem   [LIFT_DEPTH];
    logic [LSTART_W-1:0] r_lstart_mem [ROW_DEPTH];
    logic [31:0]         r_out_mem    [MAX_LABELS];
    logic [31:0]         r_in_mem     [MAX_LABELS];
    logic [PSTART_W-1:0] r_pstart_mem [ROW_DEPTH];
    logic [NODE_W-1:0]   r_pos_mem    [MAX_POSITIONS];

    logic [NODE_W-1:0]   r_da, r_db, r_lift_a, r_lift_b, r_par, r_plist;
    logic [PSTART_W-1:0] r_ps_a, r_ps_b;
    logic [LSTART_W-1:0] r_ls_s, r_ls_t;
    logic [31:0]         r_out, r_in;

    t_state       r_state, n_state;
    logic [10:0]  r_nodes;
    logic [3:0]   r_levels;
    logic [3:0]   r_lv;
    logic [9:0]   r_diff;
    logic [9:0]   r_a, r_b, r_src, r_dst, r_anc;
    logic [14:0]  r_off, r_end;
    logic [31:0]  r_best, r_res_dist;
    t_status      r_res_status;
    logic         r_ok;
    logic         r_o_valid;
    logic [31:0]  r_o_dist;
    t_status      r_o_status;

    logic [10:0]        n_c;
    logic [3:0]         lev_c;
    logic               load_we, query_go, out_free;
    logic [10:0]        diff_x;
    logic [LIFT_AW-1:0] lift_addr_a, lift_addr_b;
    logic [17:0]        si, ti;
    logic [32:0]        sum;
    logic [31:0]        sum_sat;

    assign n_c      = (r_nodes > 11'(NODE_LIMIT)) ? 11'(NODE_LIMIT) : r_nodes;
    assign lev_c    = (r_levels > 4'(MAX_LEVELS)) ? 4'(MAX_LEVELS) : r_levels;
    assign o_q_pop  = (r_state == S_IDLE) && i_q_valid;
    assign load_we  = o_q_pop && (i_q_req.cmd != CMD_QUERY);
    assign query_go = o_q_pop && (i_q_req.cmd == CMD_QUERY);
    assign out_free = !r_o_valid || !i_out_stall;
    assign diff_x   = {1'b0, r_diff};
    assign lift_addr_a = (r_state == S_UP) ? lift_idx(r_lv, n_c, r_a)
                                           : lift_idx(4'(r_lv - 4'd1), n_c, r_a);
    assign lift_addr_b = lift_idx(4'(r_lv - 4'd1), n_c, r_b);
    assign si      = 18'(r_ls_s) + 18'(r_plist);
    assign ti      = 18'(r_ls_t) + 18'(r_plist);
    assign sum     = {1'b0, r_out} + {1'b0, r_in};
    assign sum_sat = sum[32] ? ALL_ONES : sum[31:0];

    // table writes
    always_ff @(posedge i_clk) begin
        if (load_we) begin
            unique case (i_q_req.cmd)
                CMD_DEPTH:  if (i_q_req.addr < 16'(NODE_LIMIT))
                    r_depth_mem[i_q_req.addr[NODE_W-1:0]] <= i_q_req.value[NODE_W-1:0];
                CMD_PARENT: if (i_q_req.addr < 16'(NODE_LIMIT))
                    r_parent_mem[i_q_req.addr[NODE_W-1:0]] <= i_q_req.value[NODE_W-1:0];
                CMD_LIFT:   if (i_q_req.addr < 16'(LIFT_DEPTH))
                    r_lift_mem[i_q_req.addr[LIFT_AW-1:0]] <= i_q_req.value[NODE_W-1:0];
                CMD_LSTART: if (i_q_req.addr < 16'(ROW_DEPTH))
                    r_lstart_mem[i_q_req.addr[ROW_AW-1:0]] <= i_q_req.value[LSTART_W-1:0];
                CMD_OUTLBL: r_out_mem[i_q_req.addr] <= i_q_req.value;
                CMD_INLBL:  r_in_mem[i_q_req.addr] <= i_q_req.value;
                CMD_PSTART: if (i_q_req.addr < 16'(ROW_DEPTH))
                    r_pstart_mem[i_q_req.addr[ROW_AW-1:0]] <= i_q_req.value[PSTART_W-1:0];
                CMD_POS:    if (i_q_req.addr < 16'(MAX_POSITIONS))
                    r_pos_mem[i_q_req.addr[POS_AW-1:0]] <= i_q_req.value[NODE_W-1:0];
                default: ;
            endcase
        end
    end

    // table reads, registered
    always_ff @(posedge i_clk) begin
        r_da     <= r_depth_mem[i_q_req.src];
        r_db     <= r_depth_mem[i_q_req.dst];
        r_lift_a <= r_lift_mem[lift_addr_a];
        r_lift_b <= r_lift_mem[lift_addr_b];
        r_par    <= r_parent_mem[r_a];
        r_ps_a   <= r_pstart_mem[{1'b0, r_anc}];
        r_ps_b   <= r_pstart_mem[11'({1'b0, r_anc} + 11'd1)];
        r_ls_s   <= r_lstart_mem[{1'b0, r_src}];
        r_ls_t   <= r_lstart_mem[{1'b0, r_dst}];
        r_plist  <= r_pos_mem[r_off[POS_AW-1:0]];
        r_out    <= r_out_mem[si[LABEL_AW-1:0]];
        r_in     <= r_in_mem[ti[LABEL_AW-1:0]];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (query_go) begin
                    if (({1'b0, i_q_req.src} >= n_c) || ({1'b0, i_q_req.dst} >= n_c)
                        || (i_q_req.src == i_q_req.dst))
                        n_state = S_DONE;
                    else
                        n_state = S_DEPTH;
                end
            end
            S_DEPTH: n_state = S_UP;
            S_UP: begin
                if (r_lv == lev_c) n_state = (r_a == r_b) ? S_PS : S_DN;
                else if (diff_x[r_lv]) n_state = S_UPW;
            end
            S_UPW:  n_state = S_UP;
            S_DN:   n_state = (r_lv == 4'd0) ? S_PAR : S_DNW;
            S_DNW:  n_state = S_DN;
            S_PAR:  n_state = S_PS;
            S_PS:   n_state = S_PSW;
            S_PSW:  n_state = S_WALK;
            S_WALK: n_state = (r_off < r_end) ? S_WP : S_DONE;
            S_WP:   n_state = S_WL;
            S_WL:   n_state = S_WALK;
            S_DONE: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_src <= i_q_req.src;
                r_dst <= i_q_req.dst;
                if (({1'b0, i_q_req.src} >= n_c) || ({1'b0, i_q_req.dst} >= n_c)) begin
                    r_res_dist   <= ALL_ONES;
                    r_res_status <= ST_RANGE;
                end else begin
                    r_res_dist   <= '0;
                    r_res_status <= ST_OK;
                end
            end
            S_DEPTH: begin
                r_lv <= 4'd0;
                if (r_da < r_db) begin
                    r_a <= r_dst; r_b <= r_src; r_diff <= r_db - r_da;
                end else begin
                    r_a <= r_src; r_b <= r_dst; r_diff <= r_da - r_db;
                end
            end
            S_UP: begin
                if (r_lv == lev_c) r_anc <= r_a;
                else if (!diff_x[r_lv]) r_lv <= r_lv + 4'd1;
            end
            S_UPW: begin
                r_a  <= r_lift_a;
                r_lv <= r_lv + 4'd1;
            end
            S_DN: if (r_lv != 4'd0) r_lv <= r_lv - 4'd1;
            S_DNW: begin
                if (r_lift_a != r_lift_b) begin
                    r_a <= r_lift_a;
                    r_b <= r_lift_b;
                end
            end
            S_PAR: r_anc <= r_par;
            S_PS: ;
            S_PSW: begin
                r_off  <= r_ps_a;
                r_end  <= (r_ps_b > 15'(MAX_POSITIONS)) ? 15'(MAX_POSITIONS) : r_ps_b;
                r_best <= ALL_ONES;
            end
            S_WALK: begin
                if (r_off < r_end) begin
                    r_off <= r_off + 15'd1;
                end else begin
                    r_res_dist   <= r_best;
                    r_res_status <= (r_best == ALL_ONES) ? ST_INF : ST_OK;
                end
            end
            S_WP: r_ok <= (si[17:16] == 2'd0) && (ti[17:16] == 2'd0);
            S_WL: if (r_ok && (sum_sat < r_best)) r_best <= sum_sat;
            S_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && out_free) begin
            r_o_dist   <= r_res_dist;
            r_o_status <= r_res_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
            r_nodes   <= 11'd1;
            r_levels  <= 4'd1;
        end else begin
            r_state <= n_state;
            if ((r_state == S_DONE) && out_free) r_o_valid <= 1'b1;
            else if (!i_out_stall) r_o_valid <= 1'b0;
            if (i_cfg_we) begin
                unique case (t_reg_idx'(i_cfg_index))
                    REG_NODES:  r_nodes  <= i_cfg_data;
                    REG_LEVELS: r_levels <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_distance  = r_o_dist;
    assign o_status    = r_o_status;

`ifndef SYNTH
    a_inf_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_status == ST_INF) |-> r_o_dist == ALL_ONES)
        else $error("infinite status without all-ones distance");
    a_lv_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UP || r_state == S_DN) |-> r_lv <= lev_c)
        else $error("lift level past configured count");
    a_best_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WL) |=> r_best <= $past(r_best))
        else $error("running minimum grew");
`endif

endmodule
`default_nettype wire

// ----- rtl/core/tree_label_distance_query.sv -----
// Top level of the tree label distance query block.
// Load requests (commands 1..8) write at most one table entry and retire while the
// back end stays idle. A query request finds the lowest common ancestor by binary
// lifting and scans that ancestor's position row for the best out-plus-in label
// sum. The sequencer reads both depths, lifts the deeper node level by level, then
// lifts both nodes down the levels while their ancestors differ, reads the parent
// and the position row bounds and, per position, reads the list entry and both
// labels and compares; the configured lift level count is clamped to 11. The result
// waits for a free result register. Out-of-range and same-node queries go straight
// to the result state. A two-entry queue lets requests arrive while a query runs,
// and the result register frees the sequencer.
`default_nettype none
module tree_label_distance_query import tlq_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [10:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [3:0]  i_command,
    input  wire logic [15:0] i_table_address,
    input  wire logic [31:0] i_write_value,
    input  wire logic [9:0]  i_source_node,
    input  wire logic [9:0]  i_target_node,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_distance,
    output logic [1:0]       o_status
);

    logic q_valid, q_pop;
    t_req q_req;

    tlq_front u_front (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_stall, .i_command, .i_table_address,
        .i_write_value, .i_source_node, .i_target_node,
        .o_q_valid(q_valid), .o_q_req(q_req), .i_q_pop(q_pop)
    );

    tlq_back u_back (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_q_valid(q_valid), .i_q_req(q_req), .o_q_pop(q_pop),
        .o_out_valid, .i_out_stall, .o_distance, .o_status
    );

endmodule
`default_nettype wire

// ----- dv/tb_tree_label_distance_query.sv -----
// Testbench for tree_label_distance_query: table loads, random trees, checked queries.
`timescale 1ns / 1ps
module tb_tree_label_distance_query;
    import tlq_pkg::*;

    localparam int STRIDE    = 4;      // label row width used by the generated trees
    localparam int IDLE_WAIT = 100;    // longest query is well under this
    localparam int WD_LIMIT  = 5000;
    localparam logic [31:0] DIST_INF = 32'hFFFF_FFFF;

    typedef struct {
        logic [31:0] dist_val;
        t_status     status;
    } t_answer;

    typedef struct {
        t_cmd        cmd;
        logic [15:0] addr;
        logic [31:0] value;
        logic [9:0]  src;
        logic [9:0]  dst;
        bit          typed;
        logic [31:0] dist_val;
        t_status     status;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [10:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [3:0]  i_command = '0;
    logic [15:0] i_table_address = '0;
    logic [31:0] i_write_value = '0;
    logic [9:0]  i_source_node = '0;
    logic [9:0]  i_target_node = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [31:0] o_distance;
    logic [1:0]  o_status;

    tree_label_distance_query dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow of the block's tables and registers
    bit [9:0]  depth_tab [NODE_LIMIT];
    bit [9:0]  parent_tab [NODE_LIMIT];
    bit [9:0]  lift_tab [LIFT_DEPTH];
    bit [16:0] lstart_tab [ROW_DEPTH];
    bit [31:0] out_tab [MAX_LABELS];
    bit [31:0] in_tab [MAX_LABELS];
    bit [14:0] pstart_tab [ROW_DEPTH];
    bit [9:0]  pos_tab [MAX_POSITIONS];
    int unsigned cfg_nodes = 1;
    int unsigned cfg_levels = 1;

    t_answer pending_answers[$];
    int      errors = 0;
    bit      calm = 1'b0;
    int      out_hold = 0;
    int      quiet_cycles = 0;

    function automatic int unsigned lift_read(int unsigned lv, int unsigned n, int unsigned node);
        int unsigned idx;
        idx = lv * n + node;
        return idx < LIFT_DEPTH ? lift_tab[idx] : 0;
    endfunction

    function automatic void store_load(t_cmd cmd, logic [15:0] addr, logic [31:0] value);
        case (cmd)
            CMD_DEPTH:  if (addr < NODE_LIMIT) depth_tab[addr] = value[9:0];
            CMD_PARENT: if (addr < NODE_LIMIT) parent_tab[addr] = value[9:0];
            CMD_LIFT:   if (addr < LIFT_DEPTH) lift_tab[addr] = value[9:0];
            CMD_LSTART: if (addr < ROW_DEPTH) lstart_tab[addr] = value[16:0];
            CMD_OUTLBL: out_tab[addr] = value;
            CMD_INLBL:  in_tab[addr] = value;
            CMD_PSTART: if (addr < ROW_DEPTH) pstart_tab[addr] = value[14:0];
            CMD_POS:    if (addr < MAX_POSITIONS) pos_tab[addr] = value[9:0];
            default: ;
        endcase
    endfunction

    function automatic t_answer shortest_distance(int unsigned src, int unsigned dst);
        t_answer     ans;
        int unsigned n, levels, a, b, t, diff, ua, ub, anc, off, stop, si, ti;
        logic [32:0] sum;
        logic [31:0] best;
        n = cfg_nodes < NODE_LIMIT ? cfg_nodes : NODE_LIMIT;
        levels = cfg_levels < MAX_LEVELS ? cfg_levels : MAX_LEVELS;
        if (src >= n || dst >= n) begin
            ans.dist_val = DIST_INF;
            ans.status = ST_RANGE;
            return ans;
        end
        if (src == dst) begin
            ans.dist_val = '0;
            ans.status = ST_OK;
            return ans;
        end
        a = src;
        b = dst;
        if (depth_tab[a] < depth_tab[b]) begin
            t = a; a = b; b = t;
        end
        diff = depth_tab[a] - depth_tab[b];
        for (int lv = 0; lv < levels; lv++)
            if ((diff >> lv) & 1) a = lift_read(lv, n, a);
        if (a == b) begin
            anc = a;
        end else begin
            for (int lv = levels - 1; lv >= 0; lv--) begin
                ua = lift_read(lv, n, a);
                ub = lift_read(lv, n, b);
                if (ua != ub) begin
                    a = ua;
                    b = ub;
                end
            end
            anc = a < NODE_LIMIT ? parent_tab[a] : 0;
        end
        best = DIST_INF;
        off = pstart_tab[anc];
        stop = pstart_tab[anc + 1];
        if (stop > MAX_POSITIONS) stop = MAX_POSITIONS;
        for (; off < stop; off++) begin
            si = lstart_tab[src] + pos_tab[off];
            ti = lstart_tab[dst] + pos_tab[off];
            if (si < MAX_LABELS && ti < MAX_LABELS) begin
                sum = {1'b0, out_tab[si]} + {1'b0, in_tab[ti]};
                if (sum[32]) sum[31:0] = DIST_INF;
                if (sum[31:0] < best) best = sum[31:0];
            end
        end
        ans.dist_val = best;
        ans.status = best == DIST_INF ? ST_INF : ST_OK;
        return ans;
    endfunction

    // one request through the input handshake; typed rows carry their own answer
    task automatic send_request(t_cmd cmd, logic [15:0] addr, logic [31:0] value,
                                logic [9:0] src, logic [9:0] dst,
                                bit typed = 1'b0, t_answer fixed = '{32'd0, ST_OK});
        int      gap;
        t_answer ans;
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 17);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command <= cmd;
        i_table_address <= addr;
        i_write_value <= value;
        i_source_node <= src;
        i_target_node <= dst;
        forever begin
            @(negedge i_clk);
            if (!o_in_stall) break;
        end
        @(posedge i_clk);
        if (cmd == CMD_QUERY) begin
            ans = typed ? fixed : shortest_distance(src, dst);
            pending_answers = {pending_answers, ans};
        end else begin
            store_load(cmd, addr, value);
        end
    endtask

    task automatic drain_and_rest();
        i_in_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [10:0] data);
        drain_and_rest();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_NODES) cfg_nodes = data;
        else cfg_levels = data[3:0];
    endtask

    // random tree over the configured nodes, every entry a query may touch is loaded
    task automatic load_tree(int unsigned n, int unsigned levels);
        int unsigned up [MAX_LEVELS][64];
        int unsigned par, dep [64], row_end;
        int unsigned lv_eff;
        logic [31:0] lbl;
        lv_eff = levels < MAX_LEVELS ? levels : MAX_LEVELS;
        for (int v = 0; v < n; v++) begin
            par = v == 0 ? 0 : $urandom_range(0, v - 1);
            dep[v] = v == 0 ? 0 : dep[par] + 1;
            up[0][v] = par;
            send_request(CMD_DEPTH, 16'(v), {22'($urandom), 10'(dep[v])}, 10'd0, 10'd0);
            send_request(CMD_PARENT, 16'(v), {22'($urandom), 10'(par)}, 10'd0, 10'd0);
        end
        for (int k = 1; k < lv_eff; k++)
            for (int v = 0; v < n; v++) up[k][v] = up[k-1][up[k-1][v]];
        for (int k = 0; k < lv_eff; k++)
            for (int v = 0; v < n; v++)
                send_request(CMD_LIFT, 16'(k * n + v), {22'($urandom), 10'(up[k][v])},
                             10'd0, 10'd0);
        row_end = 0;
        for (int v = 0; v <= n; v++) begin
            send_request(CMD_LSTART, 16'(v), {15'($urandom), 17'(v * STRIDE)}, 10'd0, 10'd0);
            send_request(CMD_PSTART, 16'(v), {17'($urandom), 15'(row_end)}, 10'd0, 10'd0);
            if (v < n) begin
                repeat ($urandom_range(0, 7) == 0 ? 0 : $urandom_range(1, 3)) begin
                    send_request(CMD_POS, 16'(row_end),
                                 {22'($urandom), 10'($urandom_range(0, STRIDE-1))},
                                 10'd0, 10'd0);
                    row_end++;
                end
            end
        end
        for (int i = 0; i < n * STRIDE; i++) begin
            for (int side = 0; side < 2; side++) begin
                case ($urandom_range(0, 7))
                    0: lbl = DIST_INF;
                    1: lbl = 32'hF000_0000 | $urandom;
                    default: lbl = $urandom_range(0, 1000);
                endcase
                send_request(side ? CMD_INLBL : CMD_OUTLBL, 16'(i), lbl, 10'd0, 10'd0);
            end
        end
    endtask

    task automatic tree_queries(int unsigned n, int count);
        logic [9:0] s, d;
        for (int i = 0; i < count; i++) begin
            s = 10'($urandom_range(0, n - 1));
            d = 10'($urandom_range(0, n - 1));
            case ($urandom_range(0, 15))
                0: d = s;
                1: s = 10'($urandom);
                2: d = 10'($urandom);
                3: send_request(t_cmd'(4'($urandom_range(9, 15))), 16'($urandom), $urandom,
                                10'($urandom), 10'($urandom));
                4: send_request(CMD_DEPTH, 16'($urandom_range(NODE_LIMIT, 16'hFFFF)), $urandom,
                                10'd0, 10'd0);
                5: send_request($urandom_range(0, 1) ? CMD_INLBL : CMD_OUTLBL,
                                16'($urandom_range(0, n * STRIDE - 1)), $urandom,
                                10'd0, 10'd0);
                default: ;
            endcase
            send_request(CMD_QUERY, 16'($urandom), $urandom, s, d);
        end
    endtask

    // result side: stall bursts, checks, watchdog
    always @(posedge i_clk) begin
        t_answer want;
        if (out_hold > 0) begin
            out_hold <= out_hold - 1;
            i_out_stall <= 1'b1;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            out_hold <= $urandom_range(0, 16);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end

        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WD_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end

        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_answers.size() == 0) begin
                $error("unexpected result distance %h status %0d", o_distance, o_status);
                errors = errors + 1;
            end else begin
                want = pending_answers.pop_front();
                if (o_distance !== want.dist_val) begin
                    $error("distance expected %h actual %h", want.dist_val, o_distance);
                    errors = errors + 1;
                end
                if (o_status !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, o_status);
                    errors = errors + 1;
                end
            end
        end
    end

    t_row directed [] = '{
        '{CMD_QUERY,  16'hFFFF, 32'hFFFF_FFFF, 10'd0,    10'd0,    1, 32'd0,   ST_OK},
        '{CMD_QUERY,  16'h0000, 32'h0000_0000, 10'd1023, 10'd0,    1, DIST_INF, ST_RANGE},
        '{CMD_QUERY,  16'h0000, 32'h0000_0000, 10'd0,    10'd1023, 1, DIST_INF, ST_RANGE},
        '{CMD_QUERY,  16'hFFFF, 32'hFFFF_FFFF, 10'd1023, 10'd1023, 1, DIST_INF, ST_RANGE},
        '{CMD_QUERY,  16'h0000, 32'h0000_0000, 10'd1,    10'd1,    1, DIST_INF, ST_RANGE},
        '{t_cmd'(15), 16'hFFFF, 32'hFFFF_FFFF, 10'd1023, 10'd1023, 0, 32'd0,   ST_OK},
        '{t_cmd'(9),  16'h0000, 32'h0000_0000, 10'd0,    10'd0,    0, 32'd0,   ST_OK},
        '{CMD_DEPTH,  16'hFFFF, 32'hFFFF_FFFF, 10'd0,    10'd0,    0, 32'd0,   ST_OK},
        '{CMD_PARENT, 16'd1024, 32'hFFFF_FFFF, 10'd0,    10'd0,    0, 32'd0,   ST_OK},
        '{CMD_LIFT,   16'd11264, 32'hFFFF_FFFF, 10'd0,   10'd0,    0, 32'd0,   ST_OK},
        '{CMD_LSTART, 16'd1025, 32'hFFFF_FFFF, 10'd0,    10'd0,    0, 32'd0,   ST_OK},
        '{CMD_PSTART, 16'hFFFF, 32'hFFFF_FFFF, 10'd0,    10'd0,    0, 32'd0,   ST_OK},
        '{CMD_POS,    16'hFFFF, 32'hFFFF_FFFF, 10'd0,    10'd0,    0, 32'd0,   ST_OK},
        '{CMD_OUTLBL, 16'hFFFF, 32'hFFFF_FFFF, 10'd0,    10'd0,    0, 32'd0,   ST_OK},
        '{CMD_INLBL,  16'hFFFF, 32'h0000_0000, 10'd0,    10'd0,    0, 32'd0,   ST_OK},
        '{CMD_QUERY,  16'h5555, 32'hAAAA_AAAA, 10'd0,    10'd0,    1, 32'd0,   ST_OK}
    };

    initial begin
        int unsigned tree_nodes [5];
        int unsigned tree_levels [5];
        logic [9:0] node;
        tree_nodes = '{6, 10, 5, 8, 12};
        tree_levels = '{3, 5, 0, 15, 11};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i])
            send_request(directed[i].cmd, directed[i].addr, directed[i].value,
                         directed[i].src, directed[i].dst, directed[i].typed,
                         '{directed[i].dist_val, directed[i].status});

        for (int p = 0; p < 5; p++) begin
            write_reg(REG_NODES, 11'(tree_nodes[p]));
            write_reg(REG_LEVELS, 11'(tree_levels[p]));
            load_tree(tree_nodes[p], tree_levels[p]);
            tree_queries(tree_nodes[p], 40);
        end

        // largest node counts: only same-node queries, which read no table
        write_reg(REG_NODES, 11'd1024);
        write_reg(REG_LEVELS, 11'd11);
        for (int i = 0; i < 20; i++) begin
            node = i < 2 ? (i ? 10'd1023 : 10'd0) : 10'($urandom);
            send_request(CMD_QUERY, 16'($urandom), $urandom, node, node);
        end
        write_reg(REG_NODES, 11'd2047);
        write_reg(REG_LEVELS, 11'd15);
        for (int i = 0; i < 10; i++) begin
            node = 10'($urandom);
            send_request(CMD_QUERY, 16'($urandom), $urandom, node, node);
        end

        // zero nodes: every query is out of range; run flat out
        write_reg(REG_NODES, 11'd0);
        write_reg(REG_LEVELS, 11'd0);
        calm = 1'b1;
        for (int i = 0; i < 40; i++)
            send_request(CMD_QUERY, 16'($urandom), $urandom, 10'($urandom), 10'($urandom));

        drain_and_rest();
        if (errors == 0 && pending_answers.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
